### hw/rtl/smam_pkg.sv
// smam_pkg: shared constants and types of the square matrix add / multiply unit
// no dependencies; imported by every module of the unit
`timescale 1ns / 1ps

package smam_pkg;

   localparam int MAX_DIM       = 8;
   localparam int ELEMENT_WIDTH = 16;
   localparam int VALUE_WIDTH   = 35;
   localparam int IDX_WIDTH     = 3;
   localparam int DIM_WIDTH     = 4;
   localparam int ADDR_WIDTH    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
   localparam int COUNT_WIDTH   = ADDR_WIDTH + 1;
   localparam int PROD_WIDTH    = 2 * ELEMENT_WIDTH;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // register indexes
   localparam logic REG_DIM  = 1'b0;
   localparam logic REG_MODE = 1'b1;

   // operation codes
   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_MUL = 1'b1;

   typedef struct packed {
      logic [DIM_WIDTH-1:0] dim;
      logic                 mode;
   } smam_cfg_type;

   typedef struct packed {
      logic                  wr_a;
      logic                  wr_b;
      logic [ADDR_WIDTH-1:0] wr_addr;
      logic                  rd_en;
      logic [ADDR_WIDTH-1:0] a_addr;
      logic [ADDR_WIDTH-1:0] b_addr;
      logic                  first;
      logic                  last_term;
      logic                  add_mode;
      logic                  out_load;
      logic [IDX_WIDTH-1:0]  row;
      logic [IDX_WIDTH-1:0]  col;
      logic                  last;
   } smam_cmd_type;

   typedef struct packed {
      logic acc_done;
      logic out_free;
   } smam_stat_type;

endpackage

### hw/rtl/smam_if.sv
// smam_req_if / smam_rsp_if: valid-ready channels of the matrix unit
// depends on smam_pkg for the payload widths
`timescale 1ns / 1ps

interface smam_req_if;
   import smam_pkg::*;

   logic                            valid;
   logic                            ready;
   logic signed [ELEMENT_WIDTH-1:0] element;

   modport source (output valid, output element, input ready);
   modport sink (input valid, input element, output ready);
endinterface

interface smam_rsp_if;
   import smam_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;
   logic [IDX_WIDTH-1:0]          row;
   logic [IDX_WIDTH-1:0]          col;
   logic                          last;

   modport source (output valid, output value, output row, output col, output last,
                   input ready);
   modport sink (input valid, input value, input row, input col, input last,
                 output ready);
endinterface

### hw/rtl/smam_csr.sv
// smam_csr: apb-style register file holding dim and mode
// depends on smam_pkg
`timescale 1ns / 1ps

module smam_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [smam_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [smam_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [smam_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready,
   output smam_pkg::smam_cfg_type              cfg
);
   import smam_pkg::*;

   logic [DIM_WIDTH-1:0] dim_ff, dim_in;
   logic                 mode_ff, mode_in;
   logic                 wr_en;
   logic                 reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[2];

   always_comb begin
      dim_in  = dim_ff;
      mode_in = mode_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_DIM:  dim_in  = pwdata[DIM_WIDTH-1:0];
            REG_MODE: mode_in = pwdata[0];
            default:  dim_in  = dim_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_DIM:  prdata = {{(CSR_DATA_WIDTH-DIM_WIDTH){1'b0}}, dim_ff};
         REG_MODE: prdata = {{(CSR_DATA_WIDTH-1){1'b0}}, mode_ff};
         default:  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff  <= DIM_WIDTH'(1);
         mode_ff <= MODE_ADD;
      end else begin
         dim_ff  <= dim_in;
         mode_ff <= mode_in;
      end
   end

   assign cfg.dim  = dim_ff;
   assign cfg.mode = mode_ff;

endmodule

### hw/rtl/smam_dpath.sv
// smam_dpath: matrix stores, read stage, multiply / add stage, accumulator and
// output register; depends on smam_pkg, driven by smam_ctrl commands
`timescale 1ns / 1ps

module smam_dpath (
   input  logic                                      clock,
   input  logic                                      reset,
   input  smam_pkg::smam_cmd_type                    cmd,
   output smam_pkg::smam_stat_type                   stat,
   input  logic signed [smam_pkg::ELEMENT_WIDTH-1:0] element,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [smam_pkg::VALUE_WIDTH-1:0]   rsp_value,
   output logic [smam_pkg::IDX_WIDTH-1:0]            rsp_row,
   output logic [smam_pkg::IDX_WIDTH-1:0]            rsp_col,
   output logic                                      rsp_last
);
   import smam_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM;

   logic [ELEMENT_WIDTH-1:0] store_a_ff [DEPTH];
   logic [ELEMENT_WIDTH-1:0] store_b_ff [DEPTH];

   // read stage
   logic signed [ELEMENT_WIDTH-1:0] a_q_ff, b_q_ff;
   logic                            s1_valid_ff, s1_first_ff, s1_last_ff, s1_add_ff;
   // term stage
   logic signed [PROD_WIDTH-1:0]    prod;
   logic signed [VALUE_WIDTH-1:0]   term_ff, term_in;
   logic                            s2_valid_ff, s2_first_ff, s2_last_ff;
   // accumulator
   logic signed [VALUE_WIDTH-1:0]   acc_ff, acc_in;
   logic                            done_ff;
   // output register
   logic                            out_valid_ff, out_valid_in;
   logic signed [VALUE_WIDTH-1:0]   out_value_ff;
   logic [IDX_WIDTH-1:0]            out_row_ff, out_col_ff;
   logic                            out_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         store_a_ff[cmd.wr_addr] <= element;
      end
      if (cmd.wr_b) begin
         store_b_ff[cmd.wr_addr] <= element;
      end
      if (cmd.rd_en) begin
         a_q_ff <= store_a_ff[cmd.a_addr];
         b_q_ff <= store_b_ff[cmd.b_addr];
      end
   end

   assign prod    = a_q_ff * b_q_ff;
   assign term_in = s1_add_ff ? (VALUE_WIDTH'(a_q_ff) + VALUE_WIDTH'(b_q_ff))
                              : VALUE_WIDTH'(prod);
   assign acc_in  = s2_first_ff ? term_ff : (acc_ff + term_ff);

   always_ff @(posedge clock) begin
      s1_first_ff <= cmd.first;
      s1_last_ff  <= cmd.last_term;
      s1_add_ff   <= cmd.add_mode;
      term_ff     <= term_in;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
      if (cmd.out_load) begin
         out_value_ff <= acc_ff;
         out_row_ff   <= cmd.row;
         out_col_ff   <= cmd.col;
         out_last_ff  <= cmd.last;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd.rd_en;
         s2_valid_ff  <= s1_valid_ff;
         done_ff      <= s2_valid_ff & s2_last_ff;
         out_valid_ff <= out_valid_in;
      end
   end

   assign stat.acc_done = done_ff;
   assign stat.out_free = ~out_valid_ff | rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;
   assign rsp_row   = out_row_ff;
   assign rsp_col   = out_col_ff;
   assign rsp_last  = out_last_ff;

endmodule

### hw/rtl/smam_ctrl.sv
// smam_ctrl: load counter and result sequencer of the matrix unit
// depends on smam_pkg; commands smam_dpath
`timescale 1ns / 1ps

module smam_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  smam_pkg::smam_cfg_type  cfg,
   input  logic                    req_valid,
   output logic                    req_ready,
   output smam_pkg::smam_cmd_type  cmd,
   input  smam_pkg::smam_stat_type stat
);
   import smam_pkg::*;

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [IDX_WIDTH-1:0]   i_ff, i_in, j_ff, j_in, r_ff, r_in;
   logic [DIM_WIDTH-1:0]   n_ff, n_in;
   logic                   add_ff, add_in;

   logic [DIM_WIDTH-1:0]   dim_use;
   logic [COUNT_WIDTH-1:0] cells;
   logic [COUNT_WIDTH:0]   total;
   logic [COUNT_WIDTH-1:0] cnt_eff;
   logic [COUNT_WIDTH:0]   cnt_next;
   logic [COUNT_WIDTH-1:0] b_off;
   logic                   in_a;
   logic                   accept;
   logic [DIM_WIDTH-1:0]   n_last;
   logic                   r_end, j_end, i_end;
   logic [COUNT_WIDTH-1:0] row_base, a_lin, b_lin;

   // zero counts as one, anything above the maximum saturates
   always_comb begin
      if (cfg.dim == '0) begin
         dim_use = DIM_WIDTH'(1);
      end else if (cfg.dim > DIM_WIDTH'(MAX_DIM)) begin
         dim_use = DIM_WIDTH'(MAX_DIM);
      end else begin
         dim_use = cfg.dim;
      end
   end

   assign cells    = COUNT_WIDTH'(dim_use) * COUNT_WIDTH'(dim_use);
   assign total    = {cells, 1'b0};
   // a shrunken dim can leave the count past the end: restart with A
   assign cnt_eff  = ({1'b0, cnt_ff} >= total) ? '0 : cnt_ff;
   assign cnt_next = {1'b0, cnt_eff} + (COUNT_WIDTH+1)'(1);
   assign b_off    = cnt_eff - cells;
   assign in_a     = cnt_eff < cells;

   assign req_ready = (state_ff == ST_LOAD);
   assign accept    = req_ready & req_valid;

   assign n_last = n_ff - DIM_WIDTH'(1);
   assign r_end  = add_ff | ({1'b0, r_ff} == n_last);
   assign j_end  = ({1'b0, j_ff} == n_last);
   assign i_end  = ({1'b0, i_ff} == n_last);

   assign row_base = COUNT_WIDTH'(i_ff) * COUNT_WIDTH'(n_ff);
   assign a_lin    = row_base + COUNT_WIDTH'(add_ff ? j_ff : r_ff);
   assign b_lin    = add_ff ? a_lin
                            : (COUNT_WIDTH'(r_ff) * COUNT_WIDTH'(n_ff) + COUNT_WIDTH'(j_ff));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      r_in     = r_ff;
      n_in     = n_ff;
      add_in   = add_ff;

      cmd           = '0;
      cmd.wr_addr   = in_a ? cnt_eff[ADDR_WIDTH-1:0] : b_off[ADDR_WIDTH-1:0];
      cmd.a_addr    = a_lin[ADDR_WIDTH-1:0];
      cmd.b_addr    = b_lin[ADDR_WIDTH-1:0];
      cmd.first     = add_ff | (r_ff == '0);
      cmd.last_term = r_end;
      cmd.add_mode  = add_ff;
      cmd.row       = i_ff;
      cmd.col       = j_ff;
      cmd.last      = i_end & j_end;

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               cmd.wr_a = in_a;
               cmd.wr_b = ~in_a;
               if (cnt_next == total) begin
                  cnt_in   = '0;
                  n_in     = dim_use;
                  add_in   = (cfg.mode == MODE_ADD);
                  i_in     = '0;
                  j_in     = '0;
                  r_in     = '0;
                  state_in = ST_ISSUE;
               end else begin
                  cnt_in = cnt_next[COUNT_WIDTH-1:0];
               end
            end
         end
         ST_ISSUE: begin
            cmd.rd_en = 1'b1;
            if (r_end) begin
               r_in     = '0;
               state_in = ST_WAIT;
            end else begin
               r_in = r_ff + IDX_WIDTH'(1);
            end
         end
         ST_WAIT: begin
            if (stat.acc_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               if (j_end) begin
                  j_in = '0;
                  i_in = i_ff + IDX_WIDTH'(1);
               end else begin
                  j_in = j_ff + IDX_WIDTH'(1);
               end
               state_in = (i_end & j_end) ? ST_LOAD : ST_ISSUE;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         r_ff     <= '0;
         n_ff     <= DIM_WIDTH'(1);
         add_ff   <= 1'b1;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         r_ff     <= r_in;
         n_ff     <= n_in;
         add_ff   <= add_in;
      end
   end

endmodule

### hw/rtl/square_matrix_add_multiply_unit.sv
// square matrix add / multiply unit: loads A then B (dim*dim items each), then
// emits dim*dim result items. a load item is taken every cycle while loading;
// after the last B item the results are worked out one at a time by the
// single multiply-accumulate unit fed by one read port per store.
// synchronous active-high reset clears the load count, dim to 1, mode to add;
// the matrix stores are not cleared and hold garbage until loaded
`timescale 1ns / 1ps

module square_matrix_add_multiply_unit (
   input  logic                                clock,
   input  logic                                reset,
   smam_req_if.sink                            req_bus,
   smam_rsp_if.source                          rsp_bus,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [smam_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [smam_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [smam_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);
   import smam_pkg::*;

   smam_cfg_type  cfg;
   smam_cmd_type  cmd;
   smam_stat_type stat;

   // dim and mode: the user writes them over apb only while the unit is idle
   smam_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: counts load items, then walks row, column and inner index
   smam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // stores, read / multiply / accumulate pipeline and the result register;
   // the result register lets the sequencer go back to loading while the
   // last result item still waits on the output side
   smam_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .element   (req_bus.element),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_value (rsp_bus.value),
      .rsp_row   (rsp_bus.row),
      .rsp_col   (rsp_bus.col),
      .rsp_last  (rsp_bus.last)
   );

endmodule
